>>> rtl/rps_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and sequencing functions of the relay pull-in/hold supervisor.
package rps_pkg;

	localparam int unsigned PWM_PERIOD_TICKS = 4800;
	// The period is a whole multiple of 100, so a percent duty maps by one product.
	localparam logic [12:0] COMPARE_PER_PCT = 13'(PWM_PERIOD_TICKS / 100);
	localparam logic [6:0]  DUTY_FULL       = 7'd100;

	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_OFF      = 3'd1;
	localparam logic [2:0] OP_SINGLE   = 3'd2;
	localparam logic [2:0] OP_THREE    = 3'd3;
	localparam logic [2:0] OP_RESET    = 3'd4;
	localparam logic [2:0] OP_SELFTEST = 3'd5;

	localparam logic [1:0] CFG_SETTLE = 2'd0;
	localparam logic [1:0] CFG_HOLD   = 2'd1;
	localparam logic [1:0] CFG_GAP    = 2'd2;

	localparam logic [2:0] STEP_NONE = 3'd0;
	localparam logic [2:0] STEP_LAST = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ON_SINGLE,
		ST_ON_THREE,
		ST_OFF,
		ST_GAP
	} seq_st_t;

	typedef enum logic [1:0] {
		RES_WAIT,
		RES_FAIL,
		RES_PASS
	} step_res_t;

	typedef struct packed {
		logic [15:0] settle_ticks;
		logic [6:0]  hold_percent;
		logic [15:0] gap_ticks;
	} cfg_t;

	typedef struct packed {
		logic        rel;
		logic        hlth;
		seq_st_t     st;
		logic [15:0] wc;
		logic [2:0]  step;
		logic        ok;
		logic [6:0]  d1;
		logic [6:0]  d23;
	} sup_state_t;

	typedef struct packed {
		sup_state_t s;
		step_res_t  r;
	} cmd_ret_t;

	// Packed in the order of the output tdata, lowest field last.
	typedef struct packed {
		logic        passed;
		logic        done_res;
		logic        busy_res;
		logic        healthy;
		logic        relay_closed;
		logic [12:0] compare_two_three;
		logic [12:0] compare_one;
	} result_t;

	function automatic logic [6:0] hold_duty(logic [6:0] hold);
		return (hold > DUTY_FULL) ? DUTY_FULL : hold;
	endfunction

	function automatic logic [12:0] duty_to_compare(logic [6:0] duty);
		return 13'({6'd0, duty} * COMPARE_PER_PCT);
	endfunction

	function automatic logic [2:0] step_op(logic [2:0] step);
		logic [2:0] op;
		case (step)
			3'd1: op = OP_SINGLE;
			3'd3: op = OP_THREE;
			default: op = OP_OFF;
		endcase
		return op;
	endfunction

	function automatic cmd_ret_t finish_on(sup_state_t s, logic three, logic m1, logic m23,
			logic [6:0] hold);
		cmd_ret_t c;
		c.s      = s;
		c.s.rel  = 1'b1;
		c.s.d1   = hold_duty(hold);
		c.s.d23  = three ? hold_duty(hold) : 7'd0;
		c.s.hlth = !m1 && (three ? !m23 : m23);
		c.s.st   = ST_IDLE;
		c.r      = c.s.hlth ? RES_PASS : RES_FAIL;
		return c;
	endfunction

	function automatic cmd_ret_t finish_off(sup_state_t s, logic m1, logic m23);
		cmd_ret_t c;
		c.s      = s;
		c.s.rel  = 1'b0;
		c.s.hlth = m1 && m23;
		c.s.st   = ST_IDLE;
		c.r      = c.s.hlth ? RES_PASS : RES_FAIL;
		return c;
	endfunction

	function automatic cmd_ret_t start_cmd(sup_state_t s, logic [2:0] op, logic m1, logic m23,
			cfg_t cfg);
		cmd_ret_t c;
		logic     three;
		three = (op == OP_THREE);
		c.s   = s;
		c.r   = RES_WAIT;
		if (op == OP_OFF) begin
			c.s.d1  = 7'd0;
			c.s.d23 = 7'd0;
			if (cfg.settle_ticks == 16'd0) begin
				c = finish_off(c.s, m1, m23);
			end else begin
				c.s.wc = cfg.settle_ticks;
				c.s.st = ST_OFF;
			end
		end else if (!s.hlth) begin
			// An on command is refused at once while the supervisor is unhealthy.
			c.r = RES_FAIL;
		end else begin
			c.s.d1  = DUTY_FULL;
			c.s.d23 = three ? DUTY_FULL : 7'd0;
			if (cfg.settle_ticks == 16'd0) begin
				c = finish_on(c.s, three, m1, m23, cfg.hold_percent);
			end else begin
				c.s.wc = cfg.settle_ticks;
				c.s.st = three ? ST_ON_THREE : ST_ON_SINGLE;
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/rps_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file: settle time, hold duty and self-test gap.
module rps_cfg_regs
	import rps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_ticks <= 16'd100;
			cfg_q.hold_percent <= 7'd50;
			cfg_q.gap_ticks    <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SETTLE: cfg_q.settle_ticks <= cfg_wdata;
				CFG_HOLD:   cfg_q.hold_percent <= cfg_wdata[6:0];
				CFG_GAP:    cfg_q.gap_ticks    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/rps_core.sv
`timescale 1ns / 1ps
// Supervisor state and the next-state and result logic for one item.
module rps_core
	import rps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [2:0] opcode,
	input  logic       mirror_one,
	input  logic       mirror_two_three,
	input  cfg_t       cfg,
	output result_t    res
);

	sup_state_t cur_q;
	sup_state_t nxt;
	cmd_ret_t   c;
	step_res_t  r;
	logic       have_r;
	logic       going;
	logic       done;
	logic       pass;

	always_comb begin
		nxt    = cur_q;
		c      = '{s: cur_q, r: RES_WAIT};
		r      = RES_WAIT;
		have_r = 1'b0;
		going  = 1'b0;
		done   = 1'b0;
		pass   = 1'b0;
		if (cur_q.st != ST_IDLE) begin
			// Commands are dropped while a sequence runs; only ticks advance it.
			if (opcode == OP_TICK) begin
				if (nxt.wc != 16'd0) begin
					nxt.wc = nxt.wc - 16'd1;
				end
				if (nxt.wc == 16'd0) begin
					if (nxt.st == ST_GAP) begin
						nxt.st = ST_IDLE;
						c = start_cmd(nxt, step_op(nxt.step), mirror_one, mirror_two_three, cfg);
					end else if (nxt.st == ST_OFF) begin
						c = finish_off(nxt, mirror_one, mirror_two_three);
					end else begin
						c = finish_on(nxt, nxt.st == ST_ON_THREE, mirror_one, mirror_two_three,
							cfg.hold_percent);
					end
					nxt    = c.s;
					r      = c.r;
					have_r = (c.r != RES_WAIT);
				end
			end
		end else if (opcode == OP_OFF || opcode == OP_SINGLE || opcode == OP_THREE) begin
			c      = start_cmd(nxt, opcode, mirror_one, mirror_two_three, cfg);
			nxt    = c.s;
			r      = c.r;
			have_r = (c.r != RES_WAIT);
		end else if (opcode == OP_RESET) begin
			nxt.hlth = 1'b1;
			nxt.d1   = 7'd0;
			nxt.d23  = 7'd0;
			nxt.rel  = 1'b0;
			done     = 1'b1;
			pass     = 1'b1;
		end else if (opcode == OP_SELFTEST) begin
			nxt.step = 3'd1;
			nxt.ok   = 1'b1;
			c        = start_cmd(nxt, OP_SINGLE, mirror_one, mirror_two_three, cfg);
			nxt      = c.s;
			r        = c.r;
			have_r   = (c.r != RES_WAIT);
		end

		// With zero settle and gap times a whole self-test can finish on one item,
		// so the step chain is unrolled over the four self-test steps.
		going = have_r;
		for (int i = 0; i < 4; i++) begin
			if (going) begin
				if (nxt.step == STEP_NONE) begin
					done  = 1'b1;
					pass  = (r == RES_PASS);
					going = 1'b0;
				end else begin
					if (r != RES_PASS) begin
						nxt.ok = 1'b0;
					end
					if (nxt.step >= STEP_LAST) begin
						done     = 1'b1;
						pass     = nxt.ok;
						nxt.step = STEP_NONE;
						going    = 1'b0;
					end else begin
						nxt.step = nxt.step + 3'd1;
						if (cfg.gap_ticks != 16'd0) begin
							nxt.wc = cfg.gap_ticks;
							nxt.st = ST_GAP;
							going  = 1'b0;
						end else begin
							c   = start_cmd(nxt, step_op(nxt.step), mirror_one, mirror_two_three,
								cfg);
							nxt = c.s;
							r   = c.r;
							if (c.r == RES_WAIT) begin
								going = 1'b0;
							end
						end
					end
				end
			end
		end

		res.compare_one       = duty_to_compare(nxt.d1);
		res.compare_two_three = duty_to_compare(nxt.d23);
		res.relay_closed      = nxt.rel;
		res.healthy           = nxt.hlth;
		res.busy_res          = (nxt.st != ST_IDLE);
		res.done_res          = done;
		res.passed            = done && pass;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.rel  <= 1'b0;
			cur_q.hlth <= 1'b1;
			cur_q.st   <= ST_IDLE;
			cur_q.wc   <= 16'd0;
			cur_q.step <= STEP_NONE;
			cur_q.ok   <= 1'b1;
			cur_q.d1   <= 7'd0;
			cur_q.d23  <= 7'd0;
		end else if (fire) begin
			cur_q <= nxt;
		end
	end

	a_step_implies_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q.step != STEP_NONE) |-> (cur_q.st != ST_IDLE))
		else $error("self-test step pending with the sequencer idle");

	a_gap_in_selftest: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q.st == ST_GAP) |-> (cur_q.step != STEP_NONE))
		else $error("gap wait outside a self-test");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q.d1 <= DUTY_FULL) && (cur_q.d23 <= DUTY_FULL))
		else $error("coil duty above 100 percent");

	a_pullin_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q.st == ST_ON_SINGLE || cur_q.st == ST_ON_THREE) |-> (cur_q.d1 == DUTY_FULL))
		else $error("pull-in wait without full L1 duty");

	a_reset_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && cur_q.st == ST_IDLE && opcode == OP_RESET) |=>
			(cur_q.hlth && !cur_q.rel && cur_q.d1 == 7'd0))
		else $error("fault reset did not restore a healthy open relay");

endmodule

>>> rtl/relay_pullin_hold_supervisor.sv
`timescale 1ns / 1ps
// Top level of the relay pull-in/hold supervisor: stream handshake and result register.
//
// Usage: each transfer on the s_axis channel is one tick or command (opcode plus both
// mirror contact levels). Every accepted item produces exactly one result transfer on
// m_axis carrying both PWM compare values, the relay and health flags, busy, done and
// passed. Settle time, hold duty and self-test gap are written over the cfg_* port
// while no item is in flight.
// Pipeline: an item passes the input register, then the state update and the result
// register. Throughput: one item per cycle while m_axis_tready does not hold the result;
// all sequencing for an item, including a self-test that completes on one item, is
// resolved combinationally between the input register and the result register.
// Reset: arst_n clears both pipeline valid flags, sets the relay off, duties to zero,
// health to one and the configuration to settle 100, hold 50 percent, gap 100.
// Stalls: while m_axis_tready is low the result is held, one further item may still be
// accepted into the input register, and s_axis_tready then drops until the result moves.
module relay_pullin_hold_supervisor
	import rps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [2:0] opcode, [3] mirror_one, [4] mirror_two_three, [7:5] zero
	input  logic [7:0]  s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [12:0] compare_one, [25:13] compare_two_three, [26] relay_closed, [27] healthy,
	// [28] busy_res, [29] done_res, [30] passed, [31] zero
	output logic [31:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	cfg_t       cfg;
	result_t    res;
	result_t    res_s2;
	logic       valid_s2;
	logic [4:0] item_s1;
	logic       valid_s1;
	logic       adv;
	logic       fire_s1;

	assign adv           = !valid_s2 || m_axis_tready;
	assign fire_s1       = valid_s1 && adv;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= s_axis_tdata[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_s2 <= res;
		end
	end

	rps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	rps_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (fire_s1),
		.opcode           (item_s1[2:0]),
		.mirror_one       (item_s1[3]),
		.mirror_two_three (item_s1[4]),
		.cfg              (cfg),
		.res              (res)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, res_s2};

endmodule

>>> test/relay_pullin_hold_supervisor_tb.sv
`timescale 1ns / 1ps
// Self-checking stream testbench of the relay pull-in/hold supervisor with its own behavioral predictor.
module relay_pullin_hold_supervisor_tb;
	import rps_pkg::*;

	// Opcodes six and seven are not defined and must leave the supervisor untouched.
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;
	localparam int RANDOM_ITEMS = 1100;
	localparam int RANDOM_PHASES = 4;
	localparam int HOLD_OFF_CYCLES = 40;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [2:0]  op;
		logic        m1;
		logic        m23;
		logic        typed;
		result_t     res;
		logic [1:0]  reg_idx;
		logic [15:0] reg_val;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;

	// Predicted supervisor state and register copies.
	seq_st_t     p_seq;
	logic        p_relay;
	logic        p_health;
	logic [15:0] p_wait;
	logic [2:0]  p_step;
	logic        p_st_ok;
	logic [6:0]  p_duty1;
	logic [6:0]  p_duty23;
	logic [15:0] c_settle;
	logic [6:0]  c_hold;
	logic [15:0] c_gap;

	result_t     pending_results[$];
	plan_row_t   plan[$];
	int          error_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic        hold_off_req = 1'b0;
	result_t     mon_got;
	result_t     mon_want;

	relay_pullin_hold_supervisor dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic void clear_prediction();
		p_seq    = ST_IDLE;
		p_relay  = 1'b0;
		p_health = 1'b1;
		p_wait   = 16'd0;
		p_step   = STEP_NONE;
		p_st_ok  = 1'b1;
		p_duty1  = 7'd0;
		p_duty23 = 7'd0;
		c_settle = 16'd100;
		c_hold   = 7'd50;
		c_gap    = 16'd100;
	endfunction

	function automatic logic [6:0] held_duty();
		return (c_hold > DUTY_FULL) ? DUTY_FULL : c_hold;
	endfunction

	function automatic logic [12:0] pct_to_compare(logic [6:0] duty);
		int unsigned ticks;
		ticks = duty * PWM_PERIOD_TICKS / 100;
		return ticks[12:0];
	endfunction

	function automatic step_res_t close_on(logic three, logic m1, logic m23);
		p_relay  = 1'b1;
		p_duty1  = held_duty();
		p_duty23 = three ? held_duty() : 7'd0;
		p_health = !m1 && (three ? !m23 : m23);
		p_seq    = ST_IDLE;
		return p_health ? RES_PASS : RES_FAIL;
	endfunction

	function automatic step_res_t close_off(logic m1, logic m23);
		p_relay  = 1'b0;
		p_health = m1 && m23;
		p_seq    = ST_IDLE;
		return p_health ? RES_PASS : RES_FAIL;
	endfunction

	function automatic step_res_t launch(logic [2:0] op, logic m1, logic m23);
		if (op == OP_OFF) begin
			p_duty1  = 7'd0;
			p_duty23 = 7'd0;
			if (c_settle == 16'd0)
				return close_off(m1, m23);
			p_wait = c_settle;
			p_seq  = ST_OFF;
			return RES_WAIT;
		end
		if (!p_health)
			return RES_FAIL;
		p_duty1  = DUTY_FULL;
		p_duty23 = (op == OP_THREE) ? DUTY_FULL : 7'd0;
		if (c_settle == 16'd0)
			return close_on(op == OP_THREE, m1, m23);
		p_wait = c_settle;
		p_seq  = (op == OP_THREE) ? ST_ON_THREE : ST_ON_SINGLE;
		return RES_WAIT;
	endfunction

	function automatic logic [2:0] selftest_op(logic [2:0] step);
		if (step == 3'd1)
			return OP_SINGLE;
		if (step == 3'd3)
			return OP_THREE;
		return OP_OFF;
	endfunction

	// Zero-length gaps and settle times let several self-test steps finish on one item.
	function automatic void advance_selftest(step_res_t r, logic m1, logic m23,
			output logic done, output logic pass);
		logic go;
		step_res_t cur;
		go   = 1'b1;
		cur  = r;
		done = 1'b0;
		pass = 1'b0;
		while (go) begin
			if (p_step == STEP_NONE) begin
				done = 1'b1;
				pass = (cur == RES_PASS);
				go   = 1'b0;
			end else begin
				if (cur != RES_PASS)
					p_st_ok = 1'b0;
				if (p_step >= STEP_LAST) begin
					done   = 1'b1;
					pass   = p_st_ok;
					p_step = STEP_NONE;
					go     = 1'b0;
				end else begin
					p_step = p_step + 3'd1;
					if (c_gap != 16'd0) begin
						p_wait = c_gap;
						p_seq  = ST_GAP;
						go     = 1'b0;
					end else begin
						cur = launch(selftest_op(p_step), m1, m23);
						if (cur == RES_WAIT)
							go = 1'b0;
					end
				end
			end
		end
	endfunction

	function automatic result_t predict_result(logic [2:0] op, logic m1, logic m23);
		result_t   res;
		step_res_t r;
		logic      done;
		logic      pass;
		done = 1'b0;
		pass = 1'b0;
		if (p_seq != ST_IDLE) begin
			if (op == OP_TICK) begin
				if (p_wait != 16'd0)
					p_wait = p_wait - 16'd1;
				if (p_wait == 16'd0) begin
					if (p_seq == ST_GAP) begin
						p_seq = ST_IDLE;
						r = launch(selftest_op(p_step), m1, m23);
					end else if (p_seq == ST_OFF) begin
						r = close_off(m1, m23);
					end else begin
						r = close_on(p_seq == ST_ON_THREE, m1, m23);
					end
					if (r != RES_WAIT)
						advance_selftest(r, m1, m23, done, pass);
				end
			end
		end else if (op == OP_OFF || op == OP_SINGLE || op == OP_THREE) begin
			r = launch(op, m1, m23);
			if (r != RES_WAIT)
				advance_selftest(r, m1, m23, done, pass);
		end else if (op == OP_RESET) begin
			p_health = 1'b1;
			p_duty1  = 7'd0;
			p_duty23 = 7'd0;
			p_relay  = 1'b0;
			done     = 1'b1;
			pass     = 1'b1;
		end else if (op == OP_SELFTEST) begin
			p_step  = 3'd1;
			p_st_ok = 1'b1;
			r = launch(OP_SINGLE, m1, m23);
			if (r != RES_WAIT)
				advance_selftest(r, m1, m23, done, pass);
		end
		res.compare_one       = pct_to_compare(p_duty1);
		res.compare_two_three = pct_to_compare(p_duty23);
		res.relay_closed      = p_relay;
		res.healthy           = p_health;
		res.busy_res          = (p_seq != ST_IDLE);
		res.done_res          = done;
		res.passed            = done && pass;
		return res;
	endfunction

	function automatic result_t outcome(logic [12:0] c1, logic [12:0] c23, logic relay,
			logic healthy, logic busy, logic done, logic passed);
		result_t res;
		res.compare_one       = c1;
		res.compare_two_three = c23;
		res.relay_closed      = relay;
		res.healthy           = healthy;
		res.busy_res          = busy;
		res.done_res          = done;
		res.passed            = passed;
		return res;
	endfunction

	function automatic plan_row_t item_row(logic [2:0] op, logic m1, logic m23, logic typed,
			result_t res);
		plan_row_t row;
		row.kind    = ROW_ITEM;
		row.op      = op;
		row.m1      = m1;
		row.m23     = m23;
		row.typed   = typed;
		row.res     = res;
		row.reg_idx = CFG_SETTLE;
		row.reg_val = 16'd0;
		return row;
	endfunction

	function automatic plan_row_t reg_row(logic [1:0] idx, logic [15:0] value);
		plan_row_t row;
		row         = item_row(OP_TICK, 1'b0, 1'b0, 1'b0, '0);
		row.kind    = ROW_REG;
		row.reg_idx = idx;
		row.reg_val = value;
		return row;
	endfunction

	// Mirror levels that a healthy relay shows once the given command has settled.
	function automatic logic [1:0] settled_mirrors(logic [2:0] op);
		case (op)
			OP_SINGLE: return 2'b01;
			OP_THREE:  return 2'b00;
			OP_OFF:    return 2'b11;
			default:   return 2'($urandom);
		endcase
	endfunction

	function automatic int takes_effect(logic [2:0] op);
		if (p_seq != ST_IDLE)
			return (op == OP_TICK) ? 1 : 0;
		return (op >= OP_OFF && op <= OP_SELFTEST) ? 1 : 0;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("t=%0t %s expected %0d, got %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	// Called at a falling edge; returns at a falling edge after the transfer and any idle gap.
	task automatic send_item(logic [2:0] op, logic m1, logic m23, logic typed, result_t res);
		result_t predicted;
		int      gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, m23, m1, op};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predicted = predict_result(op, m1, m23);
		pending_results.push_back(typed ? res : predicted);
		@(negedge clk);
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_random(output int counted);
		logic [2:0] op;
		logic [2:0] aim;
		logic [1:0] mir;
		int         pick;
		pick = $urandom_range(0, 99);
		if (p_seq != ST_IDLE) begin
			op = (pick < 92) ? OP_TICK : 3'($urandom_range(1, 7));
			case (p_seq)
				ST_ON_SINGLE: aim = OP_SINGLE;
				ST_ON_THREE:  aim = OP_THREE;
				ST_OFF:       aim = OP_OFF;
				default:      aim = selftest_op(p_step);
			endcase
		end else begin
			if (!p_health && pick < 40) begin
				op = OP_RESET;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 12)
					op = OP_TICK;
				else if (pick < 30)
					op = OP_OFF;
				else if (pick < 50)
					op = OP_SINGLE;
				else if (pick < 68)
					op = OP_THREE;
				else if (pick < 76)
					op = OP_RESET;
				else if (pick < 94)
					op = OP_SELFTEST;
				else
					op = pick[0] ? OP_SPARE_A : OP_SPARE_B;
			end
			aim = (op == OP_SELFTEST) ? OP_SINGLE : op;
		end
		counted = takes_effect(op);
		mir = ($urandom_range(0, 99) < 85) ? settled_mirrors(aim) : 2'($urandom);
		send_item(op, mir[1], mir[0], 1'b0, '0);
	endtask

	// Stops the sender and waits until every expected transfer has arrived.
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SETTLE: c_settle = value;
			CFG_HOLD:   c_hold   = value[6:0];
			CFG_GAP:    c_gap    = value;
			default:    ;
		endcase
	endtask

	initial begin
		int hold_left;
		hold_left     = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left    = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			mon_got = m_axis_tdata[30:0];
			if (pending_results.size() == 0) begin
				$display("t=%0t unexpected result transfer, expected none, got %h", $time,
					m_axis_tdata);
				error_count++;
			end else begin
				mon_want = pending_results.pop_front();
				check_field("compare_one", mon_want.compare_one, mon_got.compare_one);
				check_field("compare_two_three", mon_want.compare_two_three,
					mon_got.compare_two_three);
				check_field("relay_closed", mon_want.relay_closed, mon_got.relay_closed);
				check_field("healthy", mon_want.healthy, mon_got.healthy);
				check_field("busy_res", mon_want.busy_res, mon_got.busy_res);
				check_field("done_res", mon_want.done_res, mon_got.done_res);
				check_field("passed", mon_want.passed, mon_got.passed);
			end
		end
	end

	initial begin
		int phase;
		int effective;
		int counted;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'd0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_SETTLE;
		cfg_wdata     = 16'd0;
		clear_prediction();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: idle behavior, undefined opcodes, busy commands, saturated hold,
		// mirror faults, refusal while unhealthy, zero waits and a full self-test.
		plan.push_back(item_row(OP_TICK, 1'b0, 1'b0, 1'b1, outcome(0, 0, 0, 1, 0, 0, 0)));
		plan.push_back(item_row(OP_SPARE_A, 1'b1, 1'b1, 1'b1, outcome(0, 0, 0, 1, 0, 0, 0)));
		plan.push_back(item_row(OP_SPARE_B, 1'b1, 1'b0, 1'b1, outcome(0, 0, 0, 1, 0, 0, 0)));
		plan.push_back(item_row(OP_RESET, 1'b0, 1'b1, 1'b1, outcome(0, 0, 0, 1, 0, 1, 1)));
		plan.push_back(reg_row(CFG_SETTLE, 16'd1));
		plan.push_back(item_row(OP_SINGLE, 1'b1, 1'b1, 1'b1, outcome(4800, 0, 0, 1, 1, 0, 0)));
		plan.push_back(item_row(OP_OFF, 1'b0, 1'b0, 1'b1, outcome(4800, 0, 0, 1, 1, 0, 0)));
		plan.push_back(item_row(OP_SPARE_B, 1'b0, 1'b0, 1'b1, outcome(4800, 0, 0, 1, 1, 0, 0)));
		plan.push_back(item_row(OP_TICK, 1'b0, 1'b1, 1'b1, outcome(2400, 0, 1, 1, 0, 1, 1)));
		plan.push_back(reg_row(CFG_HOLD, 16'hFFFF));
		plan.push_back(item_row(OP_THREE, 1'b1, 1'b1, 1'b0, '0));
		plan.push_back(item_row(OP_TICK, 1'b0, 1'b0, 1'b0, '0));
		plan.push_back(item_row(OP_OFF, 1'b0, 1'b0, 1'b0, '0));
		plan.push_back(item_row(OP_TICK, 1'b1, 1'b0, 1'b0, '0));
		plan.push_back(item_row(OP_SINGLE, 1'b0, 1'b1, 1'b0, '0));
		plan.push_back(item_row(OP_RESET, 1'b1, 1'b1, 1'b0, '0));
		plan.push_back(reg_row(CFG_SETTLE, 16'd0));
		plan.push_back(reg_row(CFG_HOLD, 16'd0));
		plan.push_back(reg_row(CFG_GAP, 16'd0));
		plan.push_back(item_row(OP_SINGLE, 1'b0, 1'b1, 1'b0, '0));
		plan.push_back(item_row(OP_THREE, 1'b0, 1'b0, 1'b0, '0));
		plan.push_back(item_row(OP_OFF, 1'b1, 1'b1, 1'b0, '0));
		plan.push_back(item_row(OP_SELFTEST, 1'b0, 1'b1, 1'b0, '0));
		plan.push_back(item_row(OP_RESET, 1'b0, 1'b0, 1'b0, '0));
		plan.push_back(reg_row(CFG_GAP, 16'd1));
		plan.push_back(reg_row(CFG_HOLD, 16'd100));
		plan.push_back(item_row(OP_SELFTEST, 1'b0, 1'b1, 1'b0, '0));
		plan.push_back(item_row(OP_TICK, 1'b1, 1'b1, 1'b0, '0));
		plan.push_back(item_row(OP_TICK, 1'b0, 1'b0, 1'b0, '0));
		plan.push_back(item_row(OP_TICK, 1'b1, 1'b1, 1'b0, '0));
		plan.push_back(item_row(OP_TICK, 1'b0, 1'b1, 1'b0, '0));
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				quiesce();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_item(plan[i].op, plan[i].m1, plan[i].m23, plan[i].typed, plan[i].res);
			end
		end

		// A long settle time, then a long self-test gap, both run to completion.
		quiesce();
		write_reg(CFG_SETTLE, 16'd260);
		write_reg(CFG_GAP, 16'd0);
		send_item(OP_OFF, 1'b1, 1'b1, 1'b0, '0);
		while (p_seq != ST_IDLE)
			send_random(counted);
		quiesce();
		write_reg(CFG_SETTLE, 16'd0);
		write_reg(CFG_GAP, 16'd60);
		send_item(OP_RESET, 1'b0, 1'b0, 1'b0, '0);
		send_item(OP_SELFTEST, 1'b0, 1'b1, 1'b0, '0);
		while (p_seq != ST_IDLE)
			send_random(counted);

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			quiesce();
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 62;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 62;
				end
				default: begin
					send_idle_pct  = 26;
					recv_stall_pct = 26;
				end
			endcase
			write_reg(CFG_SETTLE, 16'($urandom_range(0, 5)));
			write_reg(CFG_HOLD, {9'($urandom), 7'($urandom_range(0, 127))});
			write_reg(CFG_GAP, 16'($urandom_range(0, 3)));
			// With the sender never idle, a long receiver hold-off backs up the input.
			if (phase == 0)
				hold_off_req = 1'b1;
			effective = 0;
			while (effective < RANDOM_ITEMS / RANDOM_PHASES) begin
				send_random(counted);
				effective += counted;
				if (counted != 0 && effective == RANDOM_ITEMS / (2 * RANDOM_PHASES))
					quiesce();
			end
		end

		quiesce();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
